@@ rtl/core/ipt_pkg.sv @@
`timescale 1ns / 1ps

package ipt_pkg;

	localparam int SLOTS_DEF    = 64;
	localparam int TAG_BITS_DEF = 32;

	localparam int TAG_W  = 32;
	localparam int TS_W   = 64;
	localparam int SEL_W  = 6;
	localparam logic [TS_W-1:0] MIN_INIT_RST = 64'd10000000;

	typedef enum logic [1:0] {
		ACT_BEGIN,
		ACT_END,
		ACT_READ,
		ACT_CLEAR
	} action_t;

	typedef enum logic [1:0] {
		STS_OK,
		STS_FULL,
		STS_NOT_FOUND,
		STS_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FETCH,
		S_CALC,
		S_UPDATE,
		S_RESP
	} state_t;

	// per-slot timing record, one memory word
	typedef struct packed {
		logic [TS_W-1:0] start;
		logic [TS_W-1:0] total;
		logic [TS_W-1:0] min;
		logic [TS_W-1:0] max;
		logic [TS_W-1:0] calls;
	} rec_t;

	typedef struct packed {
		status_t          status;
		logic [SEL_W-1:0] idx;
		logic [TAG_W-1:0] tag;
		logic [TS_W-1:0]  total;
		logic [TS_W-1:0]  min;
		logic [TS_W-1:0]  max;
		logic [TS_W-1:0]  calls;
	} result_t;

endpackage

@@ rtl/core/interval_profile_table.sv @@
`timescale 1ns / 1ps

// Table of SLOTS tagged interval timers. A begin request restarts the slot that
// holds its tag or claims the lowest free slot; an end request adds the elapsed
// ticks to that slot's total, updates min, max and call count; a read request
// returns one slot; a clear request frees every slot. Each request gives one
// result. Begin and end scan the tag memory, which has one read port, one slot
// per cycle. A read fetches the slot's record and tag; a read of a free slot or
// a clear goes straight to its response. The block takes one request at a time;
// in_ready is high only while it is idle, which it returns to as the result is
// loaded. A result still waiting on out_ready holds the next one back at its
// final step.
module interval_profile_table #(
	parameter int SLOTS    = ipt_pkg::SLOTS_DEF,
	parameter int TAG_BITS = ipt_pkg::TAG_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       cfg_we,
	input  logic [ipt_pkg::TS_W-1:0]   cfg_wdata,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [ipt_pkg::TAG_W-1:0]  tag,
	input  logic [ipt_pkg::TS_W-1:0]   timestamp,
	input  logic [ipt_pkg::SEL_W-1:0]  slot_select,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [ipt_pkg::SEL_W-1:0]  slot_index,
	output logic [ipt_pkg::TAG_W-1:0]  slot_tag,
	output logic [ipt_pkg::TS_W-1:0]   total_time,
	output logic [ipt_pkg::TS_W-1:0]   min_time,
	output logic [ipt_pkg::TS_W-1:0]   max_time,
	output logic [ipt_pkg::TS_W-1:0]   call_count
);
	import ipt_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int SW = $clog2(SLOTS + 1);
	localparam int KW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int CW = ((IW > SEL_W) ? IW : SEL_W) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	state_t state_q, state_nxt;

	logic [TS_W-1:0]  min_init_q;
	logic [SLOTS-1:0] valid_q;

	action_t          action_q;
	logic [KW-1:0]    key_q;
	logic [TS_W-1:0]  ts_q;

	logic [SW-1:0]    scan_q;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic             free_found_q;
	logic [IW-1:0]    free_idx_q;
	logic [IW-1:0]    tgt_q;
	logic             claim_q;

	logic             cmp_vld_s1;
	logic             cmp_slot_vld_s1;
	logic [IW-1:0]    cmp_idx_s1;

	logic [KW-1:0]    key_mem [SLOTS];
	rec_t             rec_mem [SLOTS];
	logic [KW-1:0]    key_rd_s1;
	rec_t             rec_rd_q;

	logic [TS_W-1:0]  el_q;
	result_t          res_q;
	logic             out_valid_q;
	result_t          out_q;

	// control
	logic             accept;
	logic             sel_ok;
	logic [IW-1:0]    sel_idx;
	logic [IW-1:0]    scan_idx;
	logic             scan_issue;
	logic             match;
	logic             scan_done;
	logic             hit_any;
	logic [IW-1:0]    hit_sel;
	logic             key_rd_en;
	logic [IW-1:0]    key_rd_addr;
	logic             rec_rd_en;
	logic             rec_we;
	logic             key_we;
	logic             out_load;
	rec_t             rec_new;

	assign accept     = in_valid && in_ready;
	assign sel_idx    = IW'(slot_select);
	assign sel_ok     = (CW'(slot_select) < CW'(SLOTS)) && valid_q[sel_idx];
	assign scan_idx   = scan_q[IW-1:0];
	assign scan_issue = (state_q == S_SCAN) && (scan_q < SW'(SLOTS));
	assign match      = cmp_vld_s1 && cmp_slot_vld_s1 && (key_rd_s1 == key_q);
	assign scan_done  = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign hit_any    = hit_q || match;
	assign hit_sel    = hit_q ? hit_idx_q : cmp_idx_s1;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action_t'(action))
						ACT_BEGIN, ACT_END: state_nxt = S_SCAN;
						ACT_READ:           state_nxt = sel_ok ? S_FETCH : S_RESP;
						ACT_CLEAR:          state_nxt = S_RESP;
						default:            state_nxt = S_RESP;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					if (hit_any || (action_q == ACT_BEGIN && free_found_q))
						state_nxt = S_FETCH;
					else
						state_nxt = S_RESP;
				end
			end
			S_FETCH:  state_nxt = S_CALC;
			S_CALC:   state_nxt = (action_q == ACT_READ) ? S_RESP : S_UPDATE;
			S_UPDATE: state_nxt = S_RESP;
			S_RESP: begin
				if (!out_valid_q || out_ready)
					state_nxt = S_IDLE;
			end
			default:  state_nxt = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready    = 1'b0;
		key_rd_en   = 1'b0;
		key_rd_addr = scan_idx;
		rec_rd_en   = 1'b0;
		rec_we      = 1'b0;
		key_we      = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_SCAN: key_rd_en = scan_issue;
			S_FETCH: begin
				key_rd_en   = 1'b1;
				key_rd_addr = tgt_q;
				rec_rd_en   = 1'b1;
			end
			S_CALC: ;
			S_UPDATE: begin
				rec_we = 1'b1;
				key_we = claim_q;
			end
			S_RESP: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// new record for the target slot
	always_comb begin
		rec_new = rec_rd_q;
		if (action_q == ACT_BEGIN) begin
			rec_new.start = ts_q;
			if (claim_q) begin
				rec_new.total = '0;
				rec_new.min   = min_init_q;
				rec_new.max   = '0;
				rec_new.calls = '0;
			end
		end else begin
			rec_new.total = rec_rd_q.total + el_q;
			if (el_q < rec_rd_q.min)
				rec_new.min = el_q;
			if (el_q > rec_rd_q.max)
				rec_new.max = el_q;
			rec_new.calls = rec_rd_q.calls + 64'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			min_init_q      <= MIN_INIT_RST;
			valid_q         <= '0;
			scan_q          <= '0;
			hit_q           <= 1'b0;
			free_found_q    <= 1'b0;
			claim_q         <= 1'b0;
			cmp_vld_s1      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we)
				min_init_q <= cfg_wdata;

			if (accept) begin
				scan_q       <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				claim_q      <= 1'b0;
				if (action_t'(action) == ACT_CLEAR)
					valid_q <= '0;
			end

			cmp_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_q <= scan_q + SW'(1);
				// remember the lowest free slot
				if (!valid_q[scan_idx] && !free_found_q)
					free_found_q <= 1'b1;
			end
			if (match && !hit_q)
				hit_q <= 1'b1;
			if (state_q == S_SCAN && scan_done)
				claim_q <= !hit_any;

			if (key_we)
				valid_q[tgt_q] <= 1'b1;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(action);
			key_q    <= tag[KW-1:0];
			ts_q     <= timestamp;
			tgt_q    <= sel_idx;
			res_q    <= '{
				status: (action_t'(action) == ACT_READ && !sel_ok) ? STS_EMPTY : STS_OK,
				idx: (action_t'(action) == ACT_READ && !sel_ok) ? slot_select : SEL_W'(0),
				tag: '0, total: '0, min: '0, max: '0, calls: '0};
		end

		if (scan_issue) begin
			cmp_idx_s1      <= scan_idx;
			cmp_slot_vld_s1 <= valid_q[scan_idx];
			if (!valid_q[scan_idx] && !free_found_q)
				free_idx_q <= scan_idx;
		end
		if (match && !hit_q)
			hit_idx_q <= cmp_idx_s1;

		if (state_q == S_SCAN && scan_done) begin
			tgt_q <= hit_any ? hit_sel : free_idx_q;
			if (!hit_any && !(action_q == ACT_BEGIN && free_found_q))
				res_q.status <= (action_q == ACT_BEGIN) ? STS_FULL : STS_NOT_FOUND;
		end

		if (state_q == S_CALC) begin
			el_q <= ts_q - rec_rd_q.start;
			if (action_q == ACT_READ) begin
				res_q <= '{status: STS_OK, idx: SEL_W'(tgt_q), tag: TAG_W'(key_rd_s1),
					total: rec_rd_q.total, min: rec_rd_q.min, max: rec_rd_q.max,
					calls: rec_rd_q.calls};
			end
		end

		if (state_q == S_UPDATE) begin
			res_q <= '{status: STS_OK, idx: SEL_W'(tgt_q), tag: TAG_W'(key_q),
				total: rec_new.total, min: rec_new.min, max: rec_new.max,
				calls: rec_new.calls};
		end

		if (out_load)
			out_q <= res_q;
	end

	// tag and record memories
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[tgt_q] <= key_q;
		if (key_rd_en)
			key_rd_s1 <= key_mem[key_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_mem[tgt_q] <= rec_new;
		if (rec_rd_en)
			rec_rd_q <= rec_mem[tgt_q];
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign slot_index = out_q.idx;
	assign slot_tag   = out_q.tag;
	assign total_time = out_q.total;
	assign min_time   = out_q.min;
	assign max_time   = out_q.max;
	assign call_count = out_q.calls;

	a_clear_frees_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action_t'(action) == ACT_CLEAR) |=> (valid_q == '0))
		else $error("clear left a slot valid");

	a_claim_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> !valid_q[tgt_q])
		else $error("claim overwrote a valid slot");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside response step");

endmodule
